// ===== rtl/wgpg_pkg.sv =====
// Shared constants, codes and types of the wavetable gait pattern generator.
package wgpg_pkg;

    // Table geometry and leg layout
    localparam int TABLE_ROWS     = 256;
    localparam int MOTOR_COUNT    = 18;
    localparam int LEG_COUNT      = 4;
    localparam int JOINTS_PER_LEG = 4;
    localparam int LEG_MOTORS     = LEG_COUNT * JOINTS_PER_LEG;
    localparam int JOINT_SHIFT    = $clog2(JOINTS_PER_LEG);
    localparam int DEPTH          = TABLE_ROWS * MOTOR_COUNT;

    // Widths
    localparam int ROW_W       = $clog2(TABLE_ROWS);
    localparam int MOTOR_W     = $clog2(MOTOR_COUNT);
    localparam int CNT_W       = $clog2(MOTOR_COUNT + 1);
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int ANGLE_W     = 16;
    localparam int FREQ_W      = 16;
    localparam int TIME_W      = 32;
    localparam int FRAC_W      = 24;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int LOAD_ROW_W  = 8;
    localparam int LOAD_COL_W  = 5;
    localparam int MOTOR_NUM_W = 5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIT_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_FREQUENCY = 2'd2;

    // Register reset values
    localparam logic [15:0] TIME_STEP_RESET = 16'd1049;
    localparam logic [15:0] BASE_FREQ_RESET = 16'd256;

    // Request and mode codes
    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_TICK    = 1'b1;
    localparam logic MODE_SINGLE = 1'b0;
    localparam logic MODE_MANUAL = 1'b1;

    typedef struct packed {
        logic                         req_type;
        logic [LOAD_ROW_W-1:0]        table_row;
        logic [LOAD_COL_W-1:0]        table_column;
        logic signed [ANGLE_W-1:0]    table_value;
        logic signed [FREQ_W-1:0]     left_frequency;
        logic signed [FREQ_W-1:0]     right_frequency;
    } in_item_t;

    typedef struct packed {
        logic [MOTOR_NUM_W-1:0]       motor_number;
        logic signed [ANGLE_W-1:0]    joint_angle;
        logic                         last_motor;
    } out_item_t;

    // Table write port
    typedef struct packed {
        logic                 en;
        logic [ADDR_W-1:0]    addr;
        logic [ANGLE_W-1:0]   data;
    } ram_wr_t;

    // Operands of one phase-row computation
    typedef struct packed {
        logic [FRAC_W-1:0]    time_frac;
        logic [FREQ_W-1:0]    magnitude;
        logic                 negative;
    } phase_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PH_LEFT,
        ST_PH_RIGHT,
        ST_CAP_LEFT,
        ST_CAP_RIGHT,
        ST_EMIT
    } wgpg_state_t;

endpackage

// ===== rtl/wavetable_gait_pattern_generator.sv =====
// Sequence: a load request writes the table when it is accepted; a tick request computes the phase rows,
// then reads one table word per cycle while the output is not stalled.
// A new tick is accepted only once the previous tick has issued all its reads, as the angle table
// has a single read port; loads are accepted one per cycle while the block is idle.
// Reset clears time, rows, registers and handshakes; the angle table is not cleared.
module wavetable_gait_pattern_generator
    import wgpg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    wgpg_state_t state_reg, state_next;

    logic                 mode_reg;
    logic [15:0]          time_step_reg;
    logic [FREQ_W-1:0]    base_freq_reg;

    logic [TIME_W-1:0]    elapsed_reg;
    logic [ROW_W-1:0]     left_row_reg;
    logic [ROW_W-1:0]     right_row_reg;
    logic [ROW_W-1:0]     single_row_reg;
    logic [FREQ_W-1:0]    left_freq_reg;
    logic [FREQ_W-1:0]    right_freq_reg;

    logic [CNT_W-1:0]     issue_cnt_reg;
    logic                 pend_reg, pend_next;
    logic [MOTOR_W-1:0]   pend_motor_reg;
    logic                 pend_last_reg;
    logic                 m_valid_reg, m_valid_next;
    out_item_t            m_data_reg;

    logic                 s_accept;
    logic                 can_load;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ANGLE_W-1:0]   rd_data;
    logic [MOTOR_W-1:0]   cur_motor;
    logic [ROW_W-1:0]     tail_row;
    logic [ROW_W-1:0]     cur_row;
    logic [ROW_W-1:0]     phase_row;
    logic [FREQ_W-1:0]    left_mag;
    logic [FREQ_W-1:0]    right_mag;
    logic                 all_issued;
    ram_wr_t              ram_wr;
    phase_req_t           phase_req;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign can_load = !m_valid_reg || m_ready;
    assign all_issued = (issue_cnt_reg == CNT_W'(MOTOR_COUNT));

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_SINGLE;
            time_step_reg <= TIME_STEP_RESET;
            base_freq_reg <= BASE_FREQ_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_GAIT_MODE:      mode_reg      <= cfg_wdata[0];
                CFG_TIME_STEP:      time_step_reg <= cfg_wdata;
                CFG_BASE_FREQUENCY: base_freq_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Table load path
    always_comb begin
        ram_wr.en   = s_accept && (s_data.req_type == REQ_LOAD)
                      && (int'(s_data.table_row) < TABLE_ROWS)
                      && (int'(s_data.table_column) < MOTOR_COUNT);
        ram_wr.addr = ADDR_W'(s_data.table_row) * ADDR_W'(MOTOR_COUNT)
                      + ADDR_W'(s_data.table_column);
        ram_wr.data = s_data.table_value;
    end

    // Magnitudes of the signed leg frequencies
    assign left_mag  = left_freq_reg[FREQ_W-1] ? FREQ_W'(-left_freq_reg) : left_freq_reg;
    assign right_mag = right_freq_reg[FREQ_W-1] ? FREQ_W'(-right_freq_reg) : right_freq_reg;

    // Feed the phase unit: left (or single) first, right in the cycle after
    always_comb begin
        phase_req.time_frac = elapsed_reg[FRAC_W-1:0];
        phase_req.magnitude = right_mag;
        phase_req.negative  = right_freq_reg[FREQ_W-1];
        if (state_reg == ST_PH_LEFT) begin
            if (mode_reg == MODE_SINGLE) begin
                phase_req.magnitude = base_freq_reg;
                phase_req.negative  = 1'b0;
            end else begin
                phase_req.magnitude = left_mag;
                phase_req.negative  = left_freq_reg[FREQ_W-1];
            end
        end
    end

    wgpg_phase_unit u_phase (
        .aclk (aclk),
        .req  (phase_req),
        .row  (phase_row)
    );

    // Row of the motor being read
    always_comb begin
        cur_motor = issue_cnt_reg[MOTOR_W-1:0];
        tail_row  = (left_row_reg < right_row_reg) ? left_row_reg : right_row_reg;
        if (mode_reg == MODE_SINGLE) begin
            cur_row = single_row_reg;
        end else if (int'(issue_cnt_reg) < LEG_MOTORS) begin
            cur_row = (issue_cnt_reg[JOINT_SHIFT] == 1'b0) ? left_row_reg : right_row_reg;
        end else begin
            cur_row = tail_row;
        end
        rd_addr = ADDR_W'(cur_row) * ADDR_W'(MOTOR_COUNT) + ADDR_W'(cur_motor);
    end

    wgpg_angle_ram u_ram (
        .aclk    (aclk),
        .wr      (ram_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Next state and read issue
    always_comb begin
        state_next   = state_reg;
        rd_en        = 1'b0;
        pend_next    = pend_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (pend_reg && can_load) begin
            m_valid_next = 1'b1;
            pend_next    = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && (s_data.req_type == REQ_TICK)) begin
                    state_next = ST_PH_LEFT;
                end
            end
            ST_PH_LEFT:   state_next = ST_PH_RIGHT;
            ST_PH_RIGHT:  state_next = ST_CAP_LEFT;
            ST_CAP_LEFT:  state_next = ST_CAP_RIGHT;
            ST_CAP_RIGHT: state_next = ST_EMIT;
            ST_EMIT: begin
                if (!all_issued && (!pend_reg || can_load)) begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                end
                if (all_issued && (!pend_reg || can_load)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
            issue_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            if (state_reg == ST_CAP_RIGHT) begin
                issue_cnt_reg <= '0;
            end else if (rd_en) begin
                issue_cnt_reg <= issue_cnt_reg + 1'b1;
            end
        end
    end

    // Time and phase rows
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elapsed_reg    <= '0;
            left_row_reg   <= '0;
            right_row_reg  <= '0;
            single_row_reg <= '0;
        end else begin
            if (s_accept && (s_data.req_type == REQ_TICK)) begin
                elapsed_reg <= elapsed_reg + TIME_W'(time_step_reg);
            end
            if (state_reg == ST_CAP_LEFT) begin
                if (mode_reg == MODE_SINGLE) begin
                    single_row_reg <= phase_row;
                end else if (left_freq_reg != '0) begin
                    left_row_reg <= phase_row;
                end
            end
            // a zero frequency keeps the previous row
            if ((state_reg == ST_CAP_RIGHT) && (mode_reg == MODE_MANUAL)
                    && (right_freq_reg != '0)) begin
                right_row_reg <= phase_row;
            end
        end
    end

    // Latch the request frequencies
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            left_freq_reg  <= s_data.left_frequency;
            right_freq_reg <= s_data.right_frequency;
        end
    end

    // Tag each read, then move the word into the output register
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            pend_motor_reg <= cur_motor;
            pend_last_reg  <= (issue_cnt_reg == CNT_W'(MOTOR_COUNT - 1));
        end
        if (pend_reg && can_load) begin
            m_data_reg.motor_number <= MOTOR_NUM_W'(pend_motor_reg);
            m_data_reg.joint_angle  <= rd_data;
            m_data_reg.last_motor   <= pend_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/wgpg_angle_ram.sv =====
// Angle table memory: one write port, one registered read port.
module wgpg_angle_ram
    import wgpg_pkg::*;
(
    input  logic                aclk,
    input  ram_wr_t             wr,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output logic [ANGLE_W-1:0]  rd_data
);

    logic [ANGLE_W-1:0] angle_mem [DEPTH];
    logic [ANGLE_W-1:0] rd_data_reg;

    // Store one word
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            angle_mem[wr.addr] <= wr.data;
        end
    end

    // Read one word; hold the last word while no read is issued
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= angle_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/wgpg_phase_unit.sv =====
// Two-stage phase row unit: fraction of time times frequency, scaled to a row.
module wgpg_phase_unit
    import wgpg_pkg::*;
(
    input  logic               aclk,
    input  phase_req_t         req,
    output logic [ROW_W-1:0]   row
);

    localparam int SCALE_W = FRAC_W + ROW_W + 1;
    localparam int DIFF_W  = ROW_W + 1;

    logic [FRAC_W-1:0]  prod_reg;
    logic               neg_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   row_next;
    logic [SCALE_W-1:0] scaled;
    logic [ROW_W-1:0]   raw_row;
    logic [DIFF_W-1:0]  rev_row;

    // Stage 1: keep only the fractional part of the product
    always_ff @(posedge aclk) begin
        prod_reg <= FRAC_W'(req.time_frac * req.magnitude);
        neg_reg  <= req.negative;
    end

    // Stage 2: scale to a row, mirror for a reversed gait
    always_comb begin
        scaled   = SCALE_W'(prod_reg) * SCALE_W'(TABLE_ROWS);
        raw_row  = scaled[FRAC_W +: ROW_W];
        rev_row  = DIFF_W'(TABLE_ROWS) - {1'b0, raw_row};
        row_next = raw_row;
        if (neg_reg) begin
            // a mirrored row equal to the row count wraps to zero
            row_next = (raw_row == '0) ? '0 : rev_row[ROW_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        row_reg <= row_next;
    end

    assign row = row_reg;

endmodule
